[rtl/tsdc_pkg.sv]
// Shared types, reset constants and segment tables for the thermostat display controller.
// Depends on nothing; the controller top level imports it.

package tsdc_pkg;

   // Default blink period in timer ticks.
   localparam int unsigned TICKS_PER_SECOND_DEF = 30;

   // Configuration reset values.
   localparam logic [15:0] SENSOR_MISSING_RESET = 16'hF830;   // -2000 tenths
   localparam logic [3:0]  MODE_TIMEOUT_RESET   = 4'd10;

   // Field widths.
   localparam int unsigned TEMP_WIDTH      = 16;
   localparam int unsigned PHASE_WIDTH     = 5;
   localparam int unsigned TIMEOUT_WIDTH   = 4;
   localparam int unsigned SEGMENT_WIDTH   = 8;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   // Reciprocal of ten scaled by 2^19; exact for magnitudes up to 32768.
   localparam logic [15:0] RECIP_TEN       = 16'd52429;
   localparam int unsigned RECIP_TEN_SHIFT = 19;
   localparam logic [6:0]  MAX_INT_PART    = 7'd99;

   typedef enum logic [1:0] {
      REQ_REFRESH = 2'd0,
      REQ_MODE    = 2'd1,
      REQ_TICK    = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      MODE_CURRENT  = 2'd0,
      MODE_MISSING  = 2'd1,
      MODE_SET_TEMP = 2'd2,
      MODE_SET_MODE = 2'd3
   } disp_mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SENSOR_MISSING = 1'd0,
      CSR_MODE_TIMEOUT   = 1'd1
   } csr_index_type;

   // Symbol codes beyond the decimal digits.
   localparam logic [3:0] SYM_MINUS = 4'd10;
   localparam logic [3:0] SYM_DOT   = 4'd11;
   localparam logic [3:0] SYM_BLANK = 4'd12;
   localparam logic [3:0] SYM_UNDER = 4'd13;
   localparam logic [3:0] SYM_UPPER = 4'd14;

   // Active-low segment patterns for the left and right digits.
   function automatic logic [7:0] seg_table_a(input logic [3:0] sym);
      logic [7:0] pat;
      case (sym)
         4'd0:    pat = 8'h81;
         4'd1:    pat = 8'hE7;
         4'd2:    pat = 8'h49;
         4'd3:    pat = 8'h43;
         4'd4:    pat = 8'h27;
         4'd5:    pat = 8'h13;
         4'd6:    pat = 8'h11;
         4'd7:    pat = 8'h87;
         4'd8:    pat = 8'h01;
         4'd9:    pat = 8'h03;
         4'd10:   pat = 8'h7F;
         4'd11:   pat = 8'hFE;
         4'd13:   pat = 8'hFB;
         4'd14:   pat = 8'hDF;
         default: pat = 8'hFF;
      endcase
      return pat;
   endfunction

   // Active-low segment patterns for the middle digit, which is wired differently.
   function automatic logic [7:0] seg_table_b(input logic [3:0] sym);
      logic [7:0] pat;
      case (sym)
         4'd0:    pat = 8'h12;
         4'd1:    pat = 8'h7B;
         4'd2:    pat = 8'h26;
         4'd3:    pat = 8'h23;
         4'd4:    pat = 8'h4B;
         4'd5:    pat = 8'h83;
         4'd6:    pat = 8'h82;
         4'd7:    pat = 8'h1B;
         4'd8:    pat = 8'h02;
         4'd9:    pat = 8'h03;
         4'd10:   pat = 8'hEF;
         4'd11:   pat = 8'hFD;
         4'd13:   pat = 8'hF7;
         4'd14:   pat = 8'hBF;
         default: pat = 8'hFF;
      endcase
      return pat;
   endfunction

   // Tens digit of a value known to be at most 99.
   function automatic logic [3:0] tens_digit(input logic [6:0] v);
      logic [3:0] t;
      if (v >= 7'd90)      t = 4'd9;
      else if (v >= 7'd80) t = 4'd8;
      else if (v >= 7'd70) t = 4'd7;
      else if (v >= 7'd60) t = 4'd6;
      else if (v >= 7'd50) t = 4'd5;
      else if (v >= 7'd40) t = 4'd4;
      else if (v >= 7'd30) t = 4'd3;
      else if (v >= 7'd20) t = 4'd2;
      else if (v >= 7'd10) t = 4'd1;
      else                 t = 4'd0;
      return t;
   endfunction

endpackage

[rtl/thermostat_segment_display_controller.sv]
// Top level of the thermostat three-digit seven-segment display controller.
// Depends on tsdc_pkg for types, reset values and the two segment tables.
//
// Usage: each request word is a refresh, a mode request or a one-second tick.
// A refresh re-encodes the display for the current mode; a mode request
// switches mode and restarts the timeout; a tick counts the timeout down.
// Every request word produces exactly one response word that carries the three
// active-low segment bytes, the brightness and the display mode as they stand
// after that request.
// An accepted word is registered in the request register; when it is handled, its
// response is loaded into the display state and shown from then on. Throughput is
// one word per cycle while the receiver does not stall; the single combinational
// pass from the request register into the display state sets that figure.
// The display state registers are the response register: they only change
// when a new response is loaded. While the receiver stalls, the response holds,
// the request register keeps its word and req_stall rises once it is full.
// Configuration writes are always taken (csr_ready is high) and should only
// happen while the block is idle. Reset blanks the display, sets brightness to
// 255, selects the current-temperature mode and restores the register defaults.

module thermostat_segment_display_controller #(
   parameter int unsigned TICKS_PER_SECOND = tsdc_pkg::TICKS_PER_SECOND_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_type,
   input  logic signed [tsdc_pkg::TEMP_WIDTH-1:0] req_temperature,
   input  logic [tsdc_pkg::PHASE_WIDTH-1:0]       req_tick_phase,
   input  logic                                   req_output_on,
   input  logic [1:0]                             req_new_mode,
   input  logic signed [tsdc_pkg::TEMP_WIDTH-1:0] req_set_temperature,
   input  logic                                   req_heating_flag,
   // Response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [tsdc_pkg::SEGMENT_WIDTH-1:0]     rsp_segment_left,
   output logic [tsdc_pkg::SEGMENT_WIDTH-1:0]     rsp_segment_middle,
   output logic [tsdc_pkg::SEGMENT_WIDTH-1:0]     rsp_segment_right,
   output logic [7:0]                             rsp_brightness,
   output logic [1:0]                             rsp_display_mode,
   // Configuration write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tsdc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [tsdc_pkg::TEMP_WIDTH-1:0]        csr_data
);

   import tsdc_pkg::*;

   // Phase thresholds derived from the blink period.
   localparam logic [PHASE_WIDTH-1:0] HALF_PHASE = PHASE_WIDTH'(TICKS_PER_SECOND / 2);
   localparam logic signed [6:0]      TPS_S7     = 7'(TICKS_PER_SECOND);
   localparam logic signed [11:0]     RAMP_STEP  = 12'(TICKS_PER_SECOND / 2 - 1);
   localparam logic [7:0]             TPS_U8     = 8'(TICKS_PER_SECOND);
   localparam logic [7:0]             ANIM_Q1    = 8'(TICKS_PER_SECOND / 4);
   localparam logic [7:0]             ANIM_Q2    = 8'(TICKS_PER_SECOND / 2);
   localparam logic [7:0]             ANIM_Q3    = 8'(TICKS_PER_SECOND * 3 / 4);

   // Request register.
   logic                           req_full_ff, req_full_in;
   logic [1:0]                     kind_ff;
   logic signed [TEMP_WIDTH-1:0]   temp_ff;
   logic [PHASE_WIDTH-1:0]         phase_ff;
   logic                           out_on_ff;
   logic [1:0]                     new_mode_ff;
   logic signed [TEMP_WIDTH-1:0]   set_temp_ff;
   logic                           heating_ff;

   // Configuration registers.
   logic signed [TEMP_WIDTH-1:0]   missing_below_ff, missing_below_in;
   logic [TIMEOUT_WIDTH-1:0]       timeout_cfg_ff, timeout_cfg_in;

   // Display state, which doubles as the response register.
   logic                           rsp_valid_ff, rsp_valid_in;
   disp_mode_type                  mode_ff, mode_in;
   logic [TIMEOUT_WIDTH-1:0]       timeout_ff, timeout_in;
   logic [SEGMENT_WIDTH-1:0]       seg_left_ff, seg_left_in;
   logic [SEGMENT_WIDTH-1:0]       seg_mid_ff, seg_mid_in;
   logic [SEGMENT_WIDTH-1:0]       seg_right_ff, seg_right_in;
   logic [7:0]                     bright_ff, bright_in;
   logic signed [TEMP_WIDTH-1:0]   held_temp_ff, held_temp_in;
   logic                           held_heat_ff, held_heat_in;

   // Handshake.
   logic                           advance;
   logic                           req_take;

   // Number encoder.
   logic signed [TEMP_WIDTH-1:0]   num_src;
   logic                           num_neg;
   logic [TEMP_WIDTH:0]            num_mag;
   logic [32:0]                    num_prod;
   logic [11:0]                    num_quot;
   logic [3:0]                     num_frac;
   logic                           num_in_range;
   logic [6:0]                     int_part;
   logic [3:0]                     int_tens;
   logic [3:0]                     int_units;
   logic [3:0]                     hi_sym;
   logic [SEGMENT_WIDTH-1:0]       num_left, num_mid, num_right;

   // Brightness ramp and set-mode animation.
   logic signed [6:0]              ramp_dist;
   logic signed [11:0]             ramp_prod;
   logic signed [11:0]             ramp_raw;
   logic [7:0]                     ramp_value;
   logic [7:0]                     anim_count;
   logic [3:0]                     anim_sym;
   logic [3:0]                     blink_sym;
   logic                           sensor_absent;
   disp_mode_type                  checked_mode;
   logic                           heater_dot;

   assign advance   = req_full_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_full_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_segment_left   = seg_left_ff;
   assign rsp_segment_middle = seg_mid_ff;
   assign rsp_segment_right  = seg_right_ff;
   assign rsp_brightness     = bright_ff;
   assign rsp_display_mode   = mode_ff;

   // The number shown is the held set temperature in set-temperature mode and
   // the measured temperature otherwise.
   always_comb begin
      num_src  = (mode_ff == MODE_SET_TEMP) ? held_temp_ff : temp_ff;
      num_neg  = num_src[TEMP_WIDTH-1];
      num_mag  = num_neg ? ((TEMP_WIDTH+1)'(0) - {num_src[TEMP_WIDTH-1], num_src})
                         : {1'b0, num_src};
      // Integer part by reciprocal multiplication, remainder by back-subtraction.
      num_prod     = 33'(num_mag) * 33'(RECIP_TEN);
      num_quot     = 12'(num_prod >> RECIP_TEN_SHIFT);
      num_frac     = 4'(num_mag - (TEMP_WIDTH+1)'(num_quot) * (TEMP_WIDTH+1)'(10));
      num_in_range = (num_quot <= 12'(MAX_INT_PART));
      int_part     = num_quot[6:0];
      int_tens     = tens_digit(int_part);
      int_units    = 4'(int_part - 7'(int_tens) * 7'd10);
      hi_sym       = (int_tens != 4'd0) ? int_tens : SYM_BLANK;

      if (!num_in_range) begin
         num_left  = seg_table_a(SYM_UNDER);
         num_mid   = seg_table_b(SYM_UNDER);
         num_right = seg_table_a(SYM_UNDER);
      end else if (num_neg) begin
         // A minus takes the left digit; two-digit values drop the fraction.
         num_left = seg_table_a(SYM_MINUS);
         if (int_tens != 4'd0) begin
            num_mid   = seg_table_b(hi_sym);
            num_right = seg_table_a(int_units);
         end else begin
            num_mid   = seg_table_b(int_units) & seg_table_b(SYM_DOT);
            num_right = seg_table_a(num_frac);
         end
      end else begin
         num_left  = seg_table_a(hi_sym);
         num_mid   = seg_table_b(int_units) & seg_table_b(SYM_DOT);
         num_right = seg_table_a(num_frac);
      end
   end

   // Brightness ramp: dims toward mid-period and back, clamped to a byte.
   always_comb begin
      if (phase_ff < HALF_PHASE) begin
         ramp_dist = 7'({2'b00, phase_ff});
      end else begin
         ramp_dist = TPS_S7 - 7'({2'b00, phase_ff});
      end
      ramp_prod = 12'(ramp_dist) * RAMP_STEP;
      ramp_raw  = 12'sd255 - ramp_prod;
      if (ramp_raw < 12'sd0) begin
         ramp_value = 8'd0;
      end else if (ramp_raw > 12'sd255) begin
         ramp_value = 8'd255;
      end else begin
         ramp_value = ramp_raw[7:0];
      end
   end

   // Set-mode animation runs forward when heating and backward when cooling.
   always_comb begin
      anim_count = held_heat_ff ? {3'b000, phase_ff} : (TPS_U8 - {3'b000, phase_ff});
      if (anim_count < ANIM_Q1) begin
         anim_sym = SYM_DOT;
      end else if (anim_count < ANIM_Q2) begin
         anim_sym = SYM_UNDER;
      end else if (anim_count < ANIM_Q3) begin
         anim_sym = SYM_MINUS;
      end else begin
         anim_sym = SYM_UPPER;
      end
      blink_sym  = (phase_ff < HALF_PHASE) ? SYM_MINUS : SYM_BLANK;
      heater_dot = out_on_ff && ((phase_ff < 5'd3) || (phase_ff > 5'd6 && phase_ff < 5'd9));
   end

   // Sensor presence check that runs ahead of every refresh.
   always_comb begin
      sensor_absent = (temp_ff < missing_below_ff);
      checked_mode  = mode_ff;
      if (sensor_absent && mode_ff == MODE_CURRENT) begin
         checked_mode = MODE_MISSING;
      end else if (!sensor_absent && mode_ff == MODE_MISSING) begin
         checked_mode = MODE_CURRENT;
      end
   end

   // Next display state for the word in the request register.
   always_comb begin
      mode_in      = mode_ff;
      timeout_in   = timeout_ff;
      seg_left_in  = seg_left_ff;
      seg_mid_in   = seg_mid_ff;
      seg_right_in = seg_right_ff;
      bright_in    = bright_ff;
      held_temp_in = held_temp_ff;
      held_heat_in = held_heat_ff;

      case (req_kind_type'(kind_ff))
         REQ_REFRESH: begin
            mode_in = checked_mode;
            case (checked_mode)
               MODE_CURRENT: begin
                  bright_in    = 8'd255;
                  seg_left_in  = num_left;
                  seg_mid_in   = num_mid;
                  seg_right_in = num_right;
               end
               MODE_MISSING: begin
                  seg_left_in  = seg_table_a(blink_sym);
                  seg_mid_in   = seg_table_b(blink_sym);
                  seg_right_in = seg_table_a(blink_sym);
               end
               MODE_SET_TEMP: begin
                  // An expired timeout falls back to the current temperature
                  // and leaves the display as it is until the next refresh.
                  if (timeout_ff == '0) begin
                     mode_in = MODE_CURRENT;
                  end else begin
                     seg_left_in  = num_left;
                     seg_mid_in   = num_mid;
                     seg_right_in = num_right;
                     bright_in    = ramp_value;
                  end
               end
               default: begin
                  if (timeout_ff == '0) begin
                     mode_in = MODE_CURRENT;
                  end else begin
                     seg_left_in  = seg_table_a(anim_sym);
                     seg_mid_in   = seg_table_b(anim_sym);
                     seg_right_in = seg_table_a(anim_sym);
                  end
               end
            endcase
            // The heater dot is added on every refresh, expired or not.
            if (heater_dot) begin
               seg_right_in = seg_right_in & seg_table_a(SYM_DOT);
            end
         end
         REQ_MODE: begin
            // The set temperature is captured only on entry into that mode.
            if (new_mode_ff == MODE_SET_TEMP && mode_ff != MODE_SET_TEMP) begin
               held_temp_in = set_temp_ff;
               held_heat_in = heating_ff;
            end
            mode_in    = disp_mode_type'(new_mode_ff);
            timeout_in = timeout_cfg_ff;
         end
         REQ_TICK: begin
            if (timeout_ff != '0) begin
               timeout_in = timeout_ff - TIMEOUT_WIDTH'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Handshake and configuration next values.
   always_comb begin
      if (req_take) begin
         req_full_in = 1'b1;
      end else if (advance) begin
         req_full_in = 1'b0;
      end else begin
         req_full_in = req_full_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      missing_below_in = missing_below_ff;
      timeout_cfg_in   = timeout_cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SENSOR_MISSING: missing_below_in = csr_data;
            CSR_MODE_TIMEOUT:   timeout_cfg_in   = csr_data[TIMEOUT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         missing_below_ff <= SENSOR_MISSING_RESET;
         timeout_cfg_ff   <= MODE_TIMEOUT_RESET;
         mode_ff          <= MODE_CURRENT;
         timeout_ff       <= '0;
         seg_left_ff      <= '1;
         seg_mid_ff       <= '1;
         seg_right_ff     <= '1;
         bright_ff        <= 8'd255;
         held_temp_ff     <= '0;
         held_heat_ff     <= 1'b0;
      end else begin
         req_full_ff      <= req_full_in;
         rsp_valid_ff     <= rsp_valid_in;
         missing_below_ff <= missing_below_in;
         timeout_cfg_ff   <= timeout_cfg_in;
         if (advance) begin
            mode_ff      <= mode_in;
            timeout_ff   <= timeout_in;
            seg_left_ff  <= seg_left_in;
            seg_mid_ff   <= seg_mid_in;
            seg_right_ff <= seg_right_in;
            bright_ff    <= bright_in;
            held_temp_ff <= held_temp_in;
            held_heat_ff <= held_heat_in;
         end
      end
   end

   // Request payload register; no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff     <= req_type;
         temp_ff     <= req_temperature;
         phase_ff    <= req_tick_phase;
         out_on_ff   <= req_output_on;
         new_mode_ff <= req_new_mode;
         set_temp_ff <= req_set_temperature;
         heating_ff  <= req_heating_flag;
      end
   end

endmodule

[tb/tb.sv]
// Self-checking testbench for the thermostat segment display controller: directed and random
// request words, a cycle-free model of the display state, random gaps and response stalls.
// Depends on tsdc_pkg and rtl/thermostat_segment_display_controller.sv only.
`timescale 1ns / 100ps

module tb;
   import tsdc_pkg::*;

   // Blink period of the instance (the block keeps its default parameter).
   localparam int TICKS = TICKS_PER_SECOND_DEF;
   // Request code that the block must ignore apart from answering with its state.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   // Longest run of cycles with no word moving on any channel. The deliberate receiver
   // hold-off of the back-pressure test is set by HOLD_CYCLES.
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 2000;
   // Cycles allowed after the last response for anything stray to show up.
   localparam int TAIL_CYCLES = 6;
   localparam int WORDS_PER_PHASE = 200;
   localparam int PHASES = 8;

   // Segment glyphs, index is the symbol code; A is left/right wiring, B is middle wiring.
   localparam logic [14:0][7:0] GLYPH_A = {
      8'hDF, 8'hFB, 8'hFF, 8'hFE, 8'h7F, 8'h03, 8'h01, 8'h87,
      8'h11, 8'h13, 8'h27, 8'h43, 8'h49, 8'hE7, 8'h81};
   localparam logic [14:0][7:0] GLYPH_B = {
      8'hBF, 8'hF7, 8'hFF, 8'hFD, 8'hEF, 8'h03, 8'h02, 8'h1B,
      8'h82, 8'h83, 8'h4B, 8'h23, 8'h26, 8'h7B, 8'h12};

   typedef struct {
      logic [1:0]         kind;
      logic signed [15:0] temp;
      logic [4:0]         phase;
      logic               heater;
      logic [1:0]         mode;
      logic signed [15:0] setpoint;
      logic               heating;
   } req_word_type;

   typedef struct {
      logic [7:0] seg_left;
      logic [7:0] seg_middle;
      logic [7:0] seg_right;
      logic [7:0] bright;
      logic [1:0] mode;
   } display_word_type;

   logic clock;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type = REQ_REFRESH;
   logic signed [15:0] req_temperature = '0;
   logic [4:0]         req_tick_phase = '0;
   logic               req_output_on = 1'b0;
   logic [1:0]         req_new_mode = MODE_CURRENT;
   logic signed [15:0] req_set_temperature = '0;
   logic               req_heating_flag = 1'b0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_segment_left;
   logic [7:0] rsp_segment_middle;
   logic [7:0] rsp_segment_right;
   logic [7:0] rsp_brightness;
   logic [1:0] rsp_display_mode;

   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [0:0]          csr_index = CSR_SENSOR_MISSING;
   logic [15:0]         csr_data = '0;

   thermostat_segment_display_controller DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_temperature     (req_temperature),
      .req_tick_phase      (req_tick_phase),
      .req_output_on       (req_output_on),
      .req_new_mode        (req_new_mode),
      .req_set_temperature (req_set_temperature),
      .req_heating_flag    (req_heating_flag),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_segment_left    (rsp_segment_left),
      .rsp_segment_middle  (rsp_segment_middle),
      .rsp_segment_right   (rsp_segment_right),
      .rsp_brightness      (rsp_brightness),
      .rsp_display_mode    (rsp_display_mode),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Display model. These variables mirror the block's registers and are updated once for
   // every request word at the edge where the block accepts it.
   // ---------------------------------------------------------------------------------------
   logic signed [15:0] limit_missing;
   logic [3:0]         timeout_setting;
   disp_mode_type      shown_mode;
   logic [3:0]         timer_left;
   logic [7:0]         shown_seg [0:2];
   logic [7:0]         shown_bright;
   logic signed [15:0] held_setpoint;
   logic               held_heating;

   display_word_type expected_display [$];

   int  mismatch_count = 0;
   bit  req_idle_on = 1'b1;
   bit  rsp_idle_on = 1'b1;
   logic rsp_hold = 1'b0;
   int  stall_left = 0;
   int  quiet_cycles = 0;

   function automatic void fill_glyph(input logic [3:0] sym);
      shown_seg[0] = GLYPH_A[sym];
      shown_seg[1] = GLYPH_B[sym];
      shown_seg[2] = GLYPH_A[sym];
   endfunction

   // Temperature in tenths: a minus or the tens on the left, then units with a dot and tenths,
   // or for negatives with tens, tens and units. Integer parts beyond two digits: underscores.
   function automatic void encode_tenths(input int t);
      int whole, frac, units, tens, hi;
      bit negative;
      whole = t / 10;
      frac  = t % 10;
      if (whole > 99 || whole < -99) begin
         fill_glyph(SYM_UNDER);
         return;
      end
      negative = (whole < 0) || (frac < 0);
      if (negative) begin
         whole = -whole;
         frac  = -frac;
      end
      units = whole % 10;
      tens  = whole / 10;
      shown_seg[2] = GLYPH_A[frac];
      shown_seg[1] = GLYPH_B[units] & GLYPH_B[SYM_DOT];
      hi = (tens != 0) ? tens % 10 : int'(SYM_BLANK);
      shown_seg[0] = GLYPH_A[hi];
      if (negative) begin
         // With a minus sign there is no room for a tenths digit once tens are shown.
         if (tens > 0) begin
            shown_seg[2] = GLYPH_A[units];
            shown_seg[1] = GLYPH_B[hi];
         end
         shown_seg[0] = GLYPH_A[SYM_MINUS];
      end
   endfunction

   function automatic void refresh_display(input int t, input int ph, input logic heater);
      int span, level, count;
      if (t < int'(limit_missing)) begin
         if (shown_mode == MODE_CURRENT)
            shown_mode = MODE_MISSING;
      end else if (shown_mode == MODE_MISSING) begin
         shown_mode = MODE_CURRENT;
      end
      case (shown_mode)
         MODE_CURRENT: begin
            shown_bright = 8'd255;
            encode_tenths(t);
         end
         MODE_MISSING: begin
            fill_glyph(ph < TICKS / 2 ? SYM_MINUS : SYM_BLANK);
         end
         MODE_SET_TEMP: begin
            // An expired timeout only drops the mode; bytes and brightness stay as they were.
            if (timer_left == 0) begin
               shown_mode = MODE_CURRENT;
            end else begin
               encode_tenths(int'(held_setpoint));
               span  = (ph < TICKS / 2) ? ph : TICKS - ph;
               level = 255 - span * (TICKS / 2 - 1);
               if (level < 0)
                  level = 0;
               if (level > 255)
                  level = 255;
               shown_bright = level[7:0];
            end
         end
         default: begin
            if (timer_left == 0) begin
               shown_mode = MODE_CURRENT;
            end else begin
               // The animation counter runs backwards when cooling and wraps in eight bits.
               count = held_heating ? ph : (TICKS - ph) & 255;
               if (count < TICKS / 4)
                  fill_glyph(SYM_DOT);
               else if (count < TICKS / 2)
                  fill_glyph(SYM_UNDER);
               else if (count < TICKS * 3 / 4)
                  fill_glyph(SYM_MINUS);
               else
                  fill_glyph(SYM_UPPER);
            end
         end
      endcase
      if (heater && (ph < 3 || (ph > 6 && ph < 9)))
         shown_seg[2] &= GLYPH_A[SYM_DOT];
   endfunction

   function automatic display_word_type predict_display(input req_word_type w);
      display_word_type d;
      case (w.kind)
         REQ_REFRESH: begin
            refresh_display(int'(w.temp), int'(w.phase), w.heater);
         end
         REQ_MODE: begin
            // The set point is latched only when set-temperature mode is entered.
            if (w.mode == MODE_SET_TEMP && shown_mode != MODE_SET_TEMP) begin
               held_setpoint = w.setpoint;
               held_heating  = w.heating;
            end
            shown_mode = disp_mode_type'(w.mode);
            timer_left = timeout_setting;
         end
         REQ_TICK: begin
            if (timer_left != 0)
               timer_left--;
         end
         default: begin
         end
      endcase
      d.seg_left   = shown_seg[0];
      d.seg_middle = shown_seg[1];
      d.seg_right  = shown_seg[2];
      d.bright     = shown_bright;
      d.mode       = shown_mode;
      return d;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Random content.
   // ---------------------------------------------------------------------------------------
   function automatic logic signed [15:0] pick_temp();
      int v;
      case ($urandom_range(0, 9))
         0: v = int'($urandom_range(0, 65535)) - 32768;
         1: begin
            // Close to the sensor threshold so that the missing-sensor switch is exercised.
            v = int'(limit_missing) + int'($urandom_range(0, 6)) - 3;
            if (v > 32767 || v < -32768)
               v = int'(limit_missing);
         end
         2: begin
            case ($urandom_range(0, 5))
               0: v = -32768;
               1: v = 32767;
               2: v = -1000;
               3: v = -999;
               4: v = 999;
               default: v = 1000;
            endcase
         end
         default: v = int'($urandom_range(0, 2400)) - 1200;
      endcase
      return v[15:0];
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         w.kind = REQ_REFRESH;
      else if (pick < 75)
         w.kind = REQ_MODE;
      else if (pick < 98)
         w.kind = REQ_TICK;
      else
         w.kind = REQ_UNUSED;
      w.temp = pick_temp();
      // Phases past the end of the blink period are legal and occasionally sent.
      w.phase    = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(30, 31))
                                                : 5'($urandom_range(0, TICKS - 1));
      w.heater   = 1'($urandom_range(0, 1));
      w.mode     = 2'($urandom_range(0, 3));
      w.setpoint = pick_temp();
      w.heating  = 1'($urandom_range(0, 1));
      return w;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side. Every send task here is entered at a rising edge and returns at the edge
   // where its word was accepted, so the next word can be set up in the same step.
   // ---------------------------------------------------------------------------------------
   task send_word(input req_word_type w);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= w.kind;
      req_temperature     <= w.temp;
      req_tick_phase      <= w.phase;
      req_output_on       <= w.heater;
      req_new_mode        <= w.mode;
      req_set_temperature <= w.setpoint;
      req_heating_flag    <= w.heating;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      expected_display.push_back(predict_display(w));
   endtask

   task send_refresh(input int t, input int ph, input logic heater);
      req_word_type w;
      w        = random_word();
      w.kind   = REQ_REFRESH;
      w.temp   = 16'(t);
      w.phase  = 5'(ph);
      w.heater = heater;
      send_word(w);
   endtask

   task send_mode(input disp_mode_type m, input logic signed [15:0] sp, input logic heating);
      req_word_type w;
      w          = random_word();
      w.kind     = REQ_MODE;
      w.mode     = m;
      w.setpoint = sp;
      w.heating  = heating;
      send_word(w);
   endtask

   task send_kind(input logic [1:0] kind);
      req_word_type w;
      w      = random_word();
      w.kind = kind;
      send_word(w);
   endtask

   // Stop offering words and wait until every response has been taken. Every word gives a
   // response, so the block is idle once the store of expected words is empty.
   task wait_display_settled();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_display.size() != 0);
   endtask

   // Ends at a later edge than the write so that a following write starts in a later step.
   task write_register(input csr_index_type idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do
         @(posedge clock);
      while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SENSOR_MISSING: limit_missing   = data;
         CSR_MODE_TIMEOUT:   timeout_setting = data[3:0];
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Response side: the stall is drawn anew after each accepted word, and the long hold-off
   // of the back-pressure test is ORed in.
   // ---------------------------------------------------------------------------------------
   task report_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
      if (mismatch_count < 40)
         $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task check_display_word();
      display_word_type want;
      if (expected_display.size() == 0) begin
         report_mismatch("response word with none expected", 16'(rsp_segment_left), 16'h0);
         return;
      end
      want = expected_display.pop_front();
      if (rsp_segment_left !== want.seg_left)
         report_mismatch("segment_left", 16'(rsp_segment_left), 16'(want.seg_left));
      if (rsp_segment_middle !== want.seg_middle)
         report_mismatch("segment_middle", 16'(rsp_segment_middle), 16'(want.seg_middle));
      if (rsp_segment_right !== want.seg_right)
         report_mismatch("segment_right", 16'(rsp_segment_right), 16'(want.seg_right));
      if (rsp_brightness !== want.bright)
         report_mismatch("brightness", 16'(rsp_brightness), 16'(want.bright));
      if (rsp_display_mode !== want.mode)
         report_mismatch("display_mode", 16'(rsp_display_mode), 16'(want.mode));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         check_display_word();
         stall_left = rsp_idle_on ? $urandom_range(0, 12) : 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end
      rsp_stall <= (stall_left > 0) || rsp_hold;
   end

   // Watchdog: ends the run if no word moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)
          || (csr_valid && csr_ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("thermostat_segment_display_controller test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------------------

   // Number rendering: zero, small positive and negative values, a negative value whose
   // integer part is zero, the two-digit limits on both sides, underscores just past them
   // and at the top of the 16-bit range, plus the heater dot inside and outside its window.
   task test_number_encoding();
      send_kind(REQ_TICK);           // shows the blank reset display
      send_refresh(0, 0, 1'b1);
      send_refresh(5, 8, 1'b1);
      send_refresh(-9, 3, 1'b1);
      send_refresh(-123, 7, 1'b0);
      send_refresh(999, 20, 1'b0);
      send_refresh(-999, 2, 1'b1);
      send_refresh(1000, 10, 1'b0);
      send_refresh(-1000, 11, 1'b0);
      send_refresh(32767, 29, 1'b1);
   endtask

   // Sensor threshold: equal to the register is still present, one below is missing and
   // blinks dashes then blank; a valid reading brings the current display back.
   task test_sensor_missing();
      send_refresh(-2000, 5, 1'b0);
      send_refresh(-2001, 14, 1'b1);
      send_refresh(-32768, 15, 1'b0);
      send_refresh(250, 8, 1'b1);
   endtask

   // Set-temperature and set-mode displays: the brightness ramp at its deepest point and
   // past the period, the set point held against a second request, the animation running
   // forward, the ignored request code and a return to the current display.
   task test_set_modes();
      send_mode(MODE_SET_TEMP, -215, 1'b1);
      send_refresh(0, 15, 1'b0);
      send_refresh(0, 31, 1'b0);
      send_mode(MODE_SET_TEMP, 32767, 1'b0);
      send_refresh(0, 30, 1'b1);
      send_mode(MODE_SET_MODE, 0, 1'b0);
      send_refresh(0, 7, 1'b0);
      send_kind(REQ_UNUSED);
      send_mode(MODE_CURRENT, 0, 1'b0);
   endtask

   // Timeout expiry, including a zero timeout that drops the mode at the first refresh.
   // The upper data bits of the timeout register are set to show they are ignored.
   task test_mode_timeout();
      wait_display_settled();
      write_register(CSR_MODE_TIMEOUT, 16'hFFF1);
      send_mode(MODE_SET_MODE, 0, 1'b0);
      send_kind(REQ_TICK);
      send_refresh(-47, 1, 1'b1);
      wait_display_settled();
      write_register(CSR_MODE_TIMEOUT, 16'h0000);
      send_mode(MODE_SET_TEMP, -32768, 1'b0);
      send_refresh(300, 8, 1'b1);
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering words, so the
   // block fills and raises req_stall.
   task test_backpressure();
      wait_display_settled();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      repeat (40) send_word(random_word());
      wait_display_settled();
   endtask

   // Random words in phases, each with its own register setting and idling pattern. Now and
   // then the sender stops until every response is back.
   task test_random_phases();
      logic [15:0] limit_word;
      logic [3:0]  timeout_value;
      for (int p = 0; p < PHASES; p++) begin
         wait_display_settled();
         case (p)
            0: begin
               limit_word    = SENSOR_MISSING_RESET;
               timeout_value = MODE_TIMEOUT_RESET;
            end
            1: begin
               limit_word    = 16'h8000;
               timeout_value = 4'd15;
            end
            2: begin
               limit_word    = 16'h7FFF;
               timeout_value = 4'd0;
            end
            3: begin
               limit_word    = 16'h0000;
               timeout_value = 4'd1;
            end
            5: begin
               limit_word    = 16'd150;
               timeout_value = 4'd3;
            end
            7: begin
               limit_word    = 16'hFFFF;
               timeout_value = 4'd15;
            end
            default: begin
               limit_word    = 16'($urandom_range(0, 65535));
               timeout_value = 4'($urandom_range(0, 15));
            end
         endcase
         write_register(CSR_SENSOR_MISSING, limit_word);
         write_register(CSR_MODE_TIMEOUT, {12'($urandom), timeout_value});
         req_idle_on = (p % 4 == 0) || (p % 4 == 2);
         rsp_idle_on = (p % 4 == 0) || (p % 4 == 1);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if ($urandom_range(0, 59) == 0)
               wait_display_settled();
            send_word(random_word());
         end
      end
   endtask

   initial begin
      // The model starts from the block's reset state.
      limit_missing   = SENSOR_MISSING_RESET;
      timeout_setting = MODE_TIMEOUT_RESET;
      shown_mode      = MODE_CURRENT;
      timer_left      = '0;
      shown_seg[0]    = 8'hFF;
      shown_seg[1]    = 8'hFF;
      shown_seg[2]    = 8'hFF;
      shown_bright    = 8'd255;
      held_setpoint   = '0;
      held_heating    = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_number_encoding();
      test_sensor_missing();
      test_set_modes();
      test_mode_timeout();
      test_backpressure();
      test_random_phases();

      wait_display_settled();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("thermostat_segment_display_controller test passed");
      else
         $display("thermostat_segment_display_controller test failed");
      $finish;
   end

endmodule
